### sv/rtbs_pkg.sv
// ----------------------------------------------------------------------------
// rtbs_pkg
// Shared types and constants for the record table binary search core.
// ----------------------------------------------------------------------------
`default_nettype none

package rtbs_pkg;

  localparam int unsigned IDX_BITS   = 11;
  localparam int unsigned SLOT_BITS  = 10;
  localparam int unsigned PORT_KEY_BITS = 32;

  // Request type codes.
  localparam logic [1:0] REQ_WRITE  = 2'd0;
  localparam logic [1:0] REQ_SEARCH = 2'd1;
  localparam logic [1:0] REQ_MIN    = 2'd2;

  // Index returned when a find-minimum request fails.
  localparam logic [IDX_BITS-1:0] ERR_INDEX = '1;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [SLOT_BITS-1:0]     entry_index;
    logic [PORT_KEY_BITS-1:0] entry_key;
    logic                     entry_valid;
    logic [IDX_BITS-1:0]      left_bound;
    logic [IDX_BITS-1:0]      right_bound;
    logic [PORT_KEY_BITS-1:0] search_key;
  } req_t;

  typedef struct packed {
    logic [IDX_BITS-1:0] result_index;
    logic                error_flag;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LB_RD,
    ST_LB_EV,
    ST_MN_RDL,
    ST_MN_EVL,
    ST_MN_RDR,
    ST_MN_EVR,
    ST_MN_RDM,
    ST_MN_EVM,
    ST_MN_RDL2,
    ST_MN_EVL2,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

### sv/rtbs_req_if.sv
// ----------------------------------------------------------------------------
// rtbs_req_if
// Valid/ready request channel carrying one request transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface rtbs_req_if;
  logic           valid;
  logic           ready;
  rtbs_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/rtbs_rsp_if.sv
// ----------------------------------------------------------------------------
// rtbs_rsp_if
// Valid/ready response channel carrying one result transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface rtbs_rsp_if;
  logic           valid;
  logic           ready;
  rtbs_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/record_table_binary_search_core.sv
// ----------------------------------------------------------------------------
// record_table_binary_search_core
// Requests are handled one at a time. A write or an unused request type goes
// straight to its result; a leftmost search probes the middle of its window
// and halves it until it closes; a find minimum reads its left and right end
// records, then walks by probing the middle record and rereading the left one
// after each step that moves the left bound. Each probe is one read of the
// single record memory followed by an evaluation of its registered data. One
// request is in flight at a time, and the next one is accepted at the edge
// where the result can first be taken; a finished result waits while the
// output register is still full. After reset a clearing pass marks every slot
// empty; no request is accepted until it ends.
// ----------------------------------------------------------------------------
`default_nettype none

module record_table_binary_search_core #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned KEY_BITS    = 32
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  rtbs_req_if.sink      req_i,
  rtbs_rsp_if.source    rsp_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned IW = rtbs_pkg::IDX_BITS;

  // Each memory word holds the valid mark in its top bit and the key below.
  logic [KEY_BITS:0] mem_q [TABLE_DEPTH];
  logic [KEY_BITS:0] mem_rdata_q;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [KEY_BITS:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;

  rtbs_pkg::state_e state_q, state_d;

  // Search window, probe point and the keys cached from the end records.
  logic [IW-1:0]       lo_q, lo_d;
  logic [IW-1:0]       hi_q, hi_d;
  logic [IW-1:0]       mid_q, mid_d;
  logic                oob_q, oob_d;
  logic [KEY_BITS-1:0] skey_q, skey_d;
  logic [KEY_BITS-1:0] kl_q, kl_d;
  logic [KEY_BITS-1:0] kr_q, kr_d;
  logic [AW-1:0]       clr_cnt_q, clr_cnt_d;

  // Finished result, waiting to move into the output register.
  rtbs_pkg::rsp_t res_q, res_d;
  rtbs_pkg::rsp_t out_q;
  logic           out_valid_q;

  logic                req_acc;
  logic                out_free;
  logic [IW-1:0]       mid;
  logic                rd_hit;
  logic [KEY_BITS-1:0] rd_key;
  logic                clr_last;

  // An index at or past the table size reads as an empty record.
  function automatic logic in_table(input logic [IW-1:0] idx);
    return 32'(idx) < 32'(TABLE_DEPTH);
  endfunction

  assign req_i.ready = (state_q == rtbs_pkg::ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  // The sum of two 11-bit bounds needs 12 bits before the halving shift.
  assign mid    = IW'((({1'b0, lo_q}) + ({1'b0, hi_q})) >> 1);
  assign rd_hit = mem_rdata_q[KEY_BITS] && !oob_q;
  assign rd_key = mem_rdata_q[KEY_BITS-1:0];
  assign clr_last = (clr_cnt_q == AW'(TABLE_DEPTH - 1));

  // --------------------------------------------------------------------------
  // Next-state logic.
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      rtbs_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_d = rtbs_pkg::ST_IDLE;
        end
      end
      rtbs_pkg::ST_IDLE: begin
        if (req_acc) begin
          case (req_i.data.req_type)
            rtbs_pkg::REQ_SEARCH: state_d = rtbs_pkg::ST_LB_RD;
            rtbs_pkg::REQ_MIN:    state_d = rtbs_pkg::ST_MN_RDL;
            default:              state_d = rtbs_pkg::ST_DONE;
          endcase
        end
      end
      rtbs_pkg::ST_LB_RD: begin
        state_d = (hi_q > lo_q) ? rtbs_pkg::ST_LB_EV : rtbs_pkg::ST_DONE;
      end
      rtbs_pkg::ST_LB_EV: begin
        state_d = rtbs_pkg::ST_LB_RD;
      end
      rtbs_pkg::ST_MN_RDL: begin
        state_d = rtbs_pkg::ST_MN_EVL;
      end
      rtbs_pkg::ST_MN_EVL: begin
        state_d = rd_hit ? rtbs_pkg::ST_MN_RDR : rtbs_pkg::ST_DONE;
      end
      rtbs_pkg::ST_MN_RDR: begin
        state_d = rtbs_pkg::ST_MN_EVR;
      end
      rtbs_pkg::ST_MN_EVR: begin
        if (rd_hit && (lo_q <= hi_q) && (kl_q > rd_key)) begin
          state_d = rtbs_pkg::ST_MN_RDM;
        end else begin
          state_d = rtbs_pkg::ST_DONE;
        end
      end
      rtbs_pkg::ST_MN_RDM: begin
        state_d = rtbs_pkg::ST_MN_EVM;
      end
      rtbs_pkg::ST_MN_EVM: begin
        if (!rd_hit) begin
          state_d = rtbs_pkg::ST_DONE;
        end else if (rd_key > kr_q) begin
          state_d = rtbs_pkg::ST_MN_RDL2;
        end else if (kl_q > rd_key) begin
          state_d = rtbs_pkg::ST_MN_RDM;
        end else begin
          state_d = rtbs_pkg::ST_DONE;
        end
      end
      rtbs_pkg::ST_MN_RDL2: begin
        state_d = rtbs_pkg::ST_MN_EVL2;
      end
      rtbs_pkg::ST_MN_EVL2: begin
        if (rd_hit && (rd_key > kr_q)) begin
          state_d = rtbs_pkg::ST_MN_RDM;
        end else begin
          state_d = rtbs_pkg::ST_DONE;
        end
      end
      rtbs_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = rtbs_pkg::ST_IDLE;
        end
      end
      default: state_d = rtbs_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath and memory control for each state.
  // --------------------------------------------------------------------------
  always_comb begin
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    oob_d     = oob_q;
    skey_d    = skey_q;
    kl_d      = kl_q;
    kr_d      = kr_q;
    res_d     = res_q;
    clr_cnt_d = clr_cnt_q;
    mem_we    = 1'b0;
    mem_waddr = AW'(req_i.data.entry_index);
    mem_wdata = {req_i.data.entry_valid, KEY_BITS'(req_i.data.entry_key)};
    mem_raddr = AW'(lo_q);

    case (state_q)
      rtbs_pkg::ST_CLEAR: begin
        // Writing an all-zero word marks the slot empty.
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
        clr_cnt_d = AW'(clr_cnt_q + AW'(1));
      end
      rtbs_pkg::ST_IDLE: begin
        if (req_acc) begin
          lo_d   = req_i.data.left_bound;
          hi_d   = req_i.data.right_bound;
          skey_d = KEY_BITS'(req_i.data.search_key);
          res_d  = '0;
          if (req_i.data.req_type == rtbs_pkg::REQ_WRITE) begin
            // A write past the table leaves the store alone but still echoes.
            mem_we = (32'(req_i.data.entry_index) < 32'(TABLE_DEPTH));
            res_d.result_index = IW'(req_i.data.entry_index);
          end
        end
      end
      rtbs_pkg::ST_LB_RD: begin
        mem_raddr = AW'(mid);
        mid_d     = mid;
        oob_d     = !in_table(mid);
        res_d.result_index = lo_q;
        res_d.error_flag   = 1'b0;
      end
      rtbs_pkg::ST_LB_EV: begin
        // Empty records count as lying to the right of every key.
        if (rd_hit && (rd_key < skey_q)) begin
          lo_d = IW'(mid_q + IW'(1));
        end else begin
          hi_d = mid_q;
        end
      end
      rtbs_pkg::ST_MN_RDL, rtbs_pkg::ST_MN_RDL2: begin
        mem_raddr = AW'(lo_q);
        oob_d     = !in_table(lo_q);
      end
      rtbs_pkg::ST_MN_EVL: begin
        kl_d = rd_key;
        res_d.result_index = rtbs_pkg::ERR_INDEX;
        res_d.error_flag   = 1'b1;
      end
      rtbs_pkg::ST_MN_RDR: begin
        mem_raddr = AW'(hi_q);
        oob_d     = !in_table(hi_q);
      end
      rtbs_pkg::ST_MN_EVR: begin
        kr_d = rd_key;
        if (!rd_hit) begin
          // An empty right record makes the left index the answer.
          res_d.result_index = lo_q;
          res_d.error_flag   = 1'b0;
        end else if (lo_q > hi_q) begin
          res_d.result_index = rtbs_pkg::ERR_INDEX;
          res_d.error_flag   = 1'b1;
        end else begin
          res_d.result_index = lo_q;
          res_d.error_flag   = 1'b0;
        end
      end
      rtbs_pkg::ST_MN_RDM: begin
        mem_raddr = AW'(mid);
        mid_d     = mid;
        oob_d     = !in_table(mid);
      end
      rtbs_pkg::ST_MN_EVM: begin
        if (!rd_hit) begin
          res_d.result_index = rtbs_pkg::ERR_INDEX;
          res_d.error_flag   = 1'b1;
        end else if (rd_key > kr_q) begin
          // The minimum lies right of the probe; the new left key is fetched next.
          lo_d = IW'(mid_q + IW'(1));
        end else begin
          hi_d = mid_q;
          kr_d = rd_key;
          res_d.result_index = lo_q;
          res_d.error_flag   = 1'b0;
        end
      end
      rtbs_pkg::ST_MN_EVL2: begin
        kl_d = rd_key;
        if (!rd_hit) begin
          res_d.result_index = rtbs_pkg::ERR_INDEX;
          res_d.error_flag   = 1'b1;
        end else begin
          res_d.result_index = lo_q;
          res_d.error_flag   = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Record memory: one write port and one registered read port.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem_q[mem_raddr];
  end

  // --------------------------------------------------------------------------
  // Control registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rtbs_pkg::ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      if (state_q == rtbs_pkg::ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
    oob_q  <= oob_d;
    skey_q <= skey_d;
    kl_q   <= kl_d;
    kr_q   <= kr_d;
    res_q  <= res_d;
    if (state_q == rtbs_pkg::ST_DONE && out_free) begin
      out_q <= res_q;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_lb_probe_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rtbs_pkg::ST_LB_EV) |-> (lo_q <= mid_q && mid_q < hi_q))
    else $error("search probe outside its window");

  a_min_window_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rtbs_pkg::ST_MN_RDM) |-> (lo_q < hi_q))
    else $error("minimum step started on a closed window");

  a_write_done_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && req_i.data.req_type == rtbs_pkg::REQ_WRITE)
      |=> (state_q == rtbs_pkg::ST_DONE))
    else $error("write did not complete in one cycle");

  a_done_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rtbs_pkg::ST_DONE && out_free)
      |=> (out_valid_q && state_q == rtbs_pkg::ST_IDLE))
    else $error("finished result not moved to the output register");

endmodule

`default_nettype wire

### bench/rtbs_table_checker.sv
// ----------------------------------------------------------------------------
// rtbs_table_checker
// Watches the request and result channels of the record table search core.
// It keeps its own copy of the record table, predicts every result and
// compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module rtbs_table_checker #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rtbs_req_if       req_mon,
  rtbs_rsp_if       rsp_mon,
  output int        fail_count_o,
  output int        pending_o
);

  import rtbs_pkg::*;

  bit [PORT_KEY_BITS-1:0] key_copy [TABLE_DEPTH];
  bit                     present  [TABLE_DEPTH];
  rsp_t                   answer_q [$];

  // Slots at or past the table end always read as empty.
  function automatic bit slot_present(input int unsigned slot);
    return (slot < TABLE_DEPTH) && present[slot];
  endfunction

  // Empty records count as lying to the right of every key.
  function automatic int unsigned leftmost_not_below(input int unsigned lo,
                                                     input int unsigned hi,
                                                     input bit [PORT_KEY_BITS-1:0] key);
    int unsigned mid;
    while (hi > lo) begin
      mid = (lo + hi) >> 1;
      if (!slot_present(mid) || key_copy[mid] >= key) begin
        hi = mid;
      end else begin
        lo = mid + 1;
      end
    end
    return lo;
  endfunction

  function automatic rsp_t rotated_min_slot(input int unsigned lo, input int unsigned hi);
    rsp_t                   fail_ans;
    rsp_t                   ans;
    bit [PORT_KEY_BITS-1:0] kl;
    bit [PORT_KEY_BITS-1:0] kr;
    bit [PORT_KEY_BITS-1:0] km;
    int unsigned            mid;
    fail_ans = '{result_index: ERR_INDEX, error_flag: 1'b1};
    ans      = '0;
    if (!slot_present(lo)) return fail_ans;
    kl = key_copy[lo];
    if (!slot_present(hi)) begin
      ans.result_index = IDX_BITS'(lo);
      return ans;
    end
    if (lo > hi) return fail_ans;
    kr = key_copy[hi];
    while (kl > kr) begin
      mid = (lo + hi) >> 1;
      if (!slot_present(mid)) return fail_ans;
      km = key_copy[mid];
      if (km > kr) begin
        lo = mid + 1;
        if (!slot_present(lo)) return fail_ans;
        kl = key_copy[lo];
      end else begin
        hi = mid;
        kr = km;
      end
    end
    ans.result_index = IDX_BITS'(lo);
    return ans;
  endfunction

  // Applies one accepted request to the table copy and returns its answer.
  function automatic rsp_t apply_request(input req_t r);
    rsp_t ans;
    ans = '0;
    case (r.req_type)
      REQ_WRITE: begin
        if (r.entry_index < TABLE_DEPTH) begin
          key_copy[r.entry_index] = r.entry_key;
          present[r.entry_index]  = r.entry_valid;
        end
        ans.result_index = IDX_BITS'(r.entry_index);
      end
      REQ_SEARCH: begin
        ans.result_index = IDX_BITS'(leftmost_not_below(32'(r.left_bound),
                                                        32'(r.right_bound),
                                                        r.search_key));
      end
      REQ_MIN: begin
        ans = rotated_min_slot(32'(r.left_bound), 32'(r.right_bound));
      end
      default: begin
      end
    endcase
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    rsp_t got;
    rsp_t want;
    int   errs;
    errs = 0;
    if (!rst_ni) begin
      foreach (present[i]) present[i] = 1'b0;
      answer_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        got = rsp_mon.data;
        if (answer_q.size() == 0) begin
          $error("unexpected result: result_index %0d, error_flag %0d",
                 got.result_index, got.error_flag);
          errs++;
        end else begin
          want = answer_q.pop_front();
          if (got.result_index !== want.result_index) begin
            $error("result_index: expected %0d, actual %0d",
                   want.result_index, got.result_index);
            errs++;
          end
          if (got.error_flag !== want.error_flag) begin
            $error("error_flag: expected %0d, actual %0d", want.error_flag, got.error_flag);
            errs++;
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        answer_q.push_back(apply_request(req_mon.data));
      end
      fail_count_o <= fail_count_o + errs;
      pending_o    <= answer_q.size();
    end
  end

endmodule

`default_nettype wire

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the record table search core with directed and random request
// transactions under random idling on both channels, and reports the verdict
// from the count of mismatches found by the table checker.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  import rtbs_pkg::*;

  // The package names the three real request types only; the fourth code
  // must still give a zero result and leave the table alone.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int unsigned TABLE_DEPTH  = 1024;
  localparam int          N_ITEMS      = 1900;
  // The last items run with no idling on either side.
  localparam int          TAIL_ITEMS   = 150;
  // The long result hold-off starts once this many transactions have gone in.
  localparam int          HOLD_AFTER   = 400;
  localparam int          HOLD_CYCLES  = 400;
  // The longest wait for a result is that of a find minimum.
  localparam int          DRAIN_CYCLES = 64;
  localparam int          CYCLE_LIMIT  = 1_000_000;

  logic clk_i;
  logic rst_ni;

  int fail_count;
  int pending;
  int items_sent;
  bit sender_idles;
  bit quiet_tail;

  bit [PORT_KEY_BITS-1:0] seg_keys [64];

  rtbs_req_if req_ch ();
  rtbs_rsp_if rsp_ch ();

  record_table_binary_search_core #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (PORT_KEY_BITS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch.sink),
    .rsp_o  (rsp_ch.source)
  );

  rtbs_table_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) table_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon      (req_ch),
    .rsp_mon      (rsp_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Reset is applied once. The block then runs its own
  // clearing pass, during which it holds its request ready low.
  initial begin
    rst_ni <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // Every field gets a random value in its range, so that fields the request
  // type does not use still toggle all of their bits.
  function automatic req_t any_req();
    req_t r;
    case ($urandom_range(0, 2))
      0:       r.req_type = REQ_WRITE;
      1:       r.req_type = REQ_SEARCH;
      default: r.req_type = REQ_MIN;
    endcase
    r.entry_index = SLOT_BITS'($urandom_range(0, TABLE_DEPTH - 1));
    r.entry_key   = $urandom;
    r.entry_valid = 1'($urandom_range(0, 1));
    r.left_bound  = IDX_BITS'($urandom_range(0, TABLE_DEPTH));
    r.right_bound = IDX_BITS'($urandom_range(0, TABLE_DEPTH));
    r.search_key  = $urandom;
    return r;
  endfunction

  function automatic req_t make_write(input int unsigned slot,
                                      input bit [PORT_KEY_BITS-1:0] key,
                                      input bit present);
    req_t r;
    r             = any_req();
    r.req_type    = REQ_WRITE;
    r.entry_index = SLOT_BITS'(slot);
    r.entry_key   = key;
    r.entry_valid = present;
    return r;
  endfunction

  function automatic req_t make_query(input logic [1:0] kind, input int unsigned lo,
                                      input int unsigned hi,
                                      input bit [PORT_KEY_BITS-1:0] key);
    req_t r;
    r             = any_req();
    r.req_type    = kind;
    r.left_bound  = IDX_BITS'(lo);
    r.right_bound = IDX_BITS'(hi);
    r.search_key  = key;
    return r;
  endfunction

  // Offers one request transaction and returns at the edge that takes it.
  // Ready is sampled at the falling edge, where it already holds the value
  // that the next rising edge will see, so acceptance never depends on the
  // order of updates inside the rising-edge time step.
  task automatic send_item(input req_t item);
    bit took;
    if (sender_idles && !quiet_tail && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= item;
    do begin
      @(negedge clk_i);
      took = req_ch.ready;
      @(posedge clk_i);
    end while (!took);
    items_sent++;
    quiet_tail = (items_sent >= N_ITEMS - TAIL_ITEMS);
  endtask

  // Writes one run of consecutive records and queries it a few times. Keys
  // ascend, with repeats allowed; a rotated run suits the find minimum,
  // a plain one the leftmost search. Some runs end in empty records, which
  // the search treats as lying to the right, and a few get an empty record
  // punched into the middle to break the walk.
  task automatic run_segment();
    int unsigned            len;
    int unsigned            base;
    int unsigned            rot;
    int unsigned            tail_empty;
    int unsigned            hole;
    int unsigned            a;
    int unsigned            b;
    int unsigned            j;
    longint unsigned        k;
    longint unsigned        step_max;
    bit [PORT_KEY_BITS-1:0] probe;
    bit                     rotated;
    len        = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
    base       = ($urandom_range(0, 5) == 0) ? TABLE_DEPTH - len
                                             : $urandom_range(0, TABLE_DEPTH - len);
    rotated    = 1'($urandom_range(0, 1));
    rot        = rotated ? $urandom_range(0, len - 1) : 0;
    k          = ($urandom_range(0, 3) == 0) ? 64'd0 : 64'($urandom);
    step_max   = ($urandom_range(0, 2) == 0) ? 64'd2 : (64'hFFFF_FFFF - k) / 64'(len);
    tail_empty = (!rotated && $urandom_range(0, 2) == 0) ? $urandom_range(1, len) : 0;
    hole       = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len - 1) : len;
    for (int i = 0; i < len; i++) begin
      seg_keys[i] = k[PORT_KEY_BITS-1:0];
      k += 64'($urandom_range(0, 32'(step_max)));
      if (k > 64'hFFFF_FFFF) k = 64'hFFFF_FFFF;
    end
    for (int i = 0; i < len; i++) begin
      send_item(make_write(base + i, seg_keys[(i + rot) % len],
                           !(i >= len - tail_empty || i == hole)));
    end
    repeat ($urandom_range(2, 6)) begin
      if (rotated ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 3) == 0)) begin
        a = 0;
        b = len - 1;
        if ($urandom_range(0, 3) == 0) begin
          a = $urandom_range(0, len - 1);
          b = $urandom_range(a, len - 1);
        end
        send_item(make_query(REQ_MIN, base + a, base + b, $urandom));
      end else begin
        a = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len) : 0;
        b = ($urandom_range(0, 3) == 0) ? $urandom_range(a, len) : len;
        b = base + b;
        // Now and then the range runs on past the run, up to the table end.
        if ($urandom_range(0, 7) == 0) b = $urandom_range(base + a, TABLE_DEPTH);
        j = $urandom_range(0, len - 1);
        case ($urandom_range(0, 5))
          0:       probe = seg_keys[j] + 1;
          1:       probe = seg_keys[j] - 1;
          2:       probe = $urandom;
          3:       probe = ($urandom_range(0, 1) == 0) ? '0 : '1;
          default: probe = seg_keys[j];
        endcase
        send_item(make_query(REQ_SEARCH, base + a, b, probe));
      end
    end
  endtask

  // Noise: fully random requests, now and then the unused request type.
  function automatic req_t noise_item();
    req_t r;
    r = any_req();
    if ($urandom_range(0, 15) == 0) r.req_type = REQ_UNUSED;
    return r;
  endfunction

  initial begin : stimulus
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    items_sent   = 0;
    sender_idles = 1'b0;
    quiet_tail   = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // Table ends hold the smallest and the largest key.
    send_item(make_write(0, '0, 1'b1));
    send_item(make_write(TABLE_DEPTH - 1, '1, 1'b1));
    // Searches over the whole table for the extreme keys.
    send_item(make_query(REQ_SEARCH, 0, TABLE_DEPTH, '0));
    send_item(make_query(REQ_SEARCH, 0, TABLE_DEPTH, '1));
    // Empty search ranges give back the left bound, at the top index too.
    send_item(make_query(REQ_SEARCH, TABLE_DEPTH, TABLE_DEPTH, $urandom));
    send_item(make_query(REQ_SEARCH, 700, 3, $urandom));
    // Find minimum with an empty left record fails.
    send_item(make_query(REQ_MIN, 5, TABLE_DEPTH - 1, $urandom));
    // Right record past the table end reads empty, so the left bound returns.
    send_item(make_query(REQ_MIN, 0, TABLE_DEPTH, $urandom));
    // Both end records present but left above right: malformed range.
    send_item(make_query(REQ_MIN, TABLE_DEPTH - 1, 0, $urandom));
    // A rotated run with an empty record that the walk lands on.
    send_item(make_write(10, 50, 1'b1));
    send_item(make_write(11, $urandom, 1'b0));
    send_item(make_write(12, 5, 1'b1));
    send_item(make_write(13, 8, 1'b1));
    send_item(make_query(REQ_MIN, 10, 13, $urandom));
    // A clean rotated run whose minimum sits at slot 22.
    send_item(make_write(20, 30, 1'b1));
    send_item(make_write(21, 40, 1'b1));
    send_item(make_write(22, 10, 1'b1));
    send_item(make_write(23, 20, 1'b1));
    send_item(make_query(REQ_MIN, 20, 23, $urandom));
    send_item(make_query(REQ_SEARCH, 20, 24, 35));
    // The unused request type, then emptying the last slot.
    send_item(make_query(REQ_UNUSED, $urandom_range(0, TABLE_DEPTH),
                         $urandom_range(0, TABLE_DEPTH), $urandom));
    send_item(make_write(TABLE_DEPTH - 1, $urandom, 1'b0));
    send_item(make_query(REQ_SEARCH, 1000, TABLE_DEPTH, '1));
    // Left bound at the table end reads empty.
    send_item(make_query(REQ_MIN, TABLE_DEPTH, TABLE_DEPTH, $urandom));

    // Random part: mostly well-formed runs, the rest noise.
    while (items_sent < N_ITEMS) begin
      if ($urandom_range(0, 5) == 0) sender_idles = !sender_idles;
      if ($urandom_range(0, 9) < 7) begin
        run_segment();
      end else begin
        repeat ($urandom_range(1, 8)) send_item(noise_item());
      end
    end
    req_ch.valid <= 1'b0;

    // The pending count is registered, so let one edge pass before trusting it.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Result side: random stall bursts that come and go in stretches, one long
  // hold-off that fills the block and backs up its request channel, and no
  // stalls at all in the tail of the run.
  initial begin : result_acceptance
    bit held_off;
    bit stalls_on;
    rsp_ch.ready <= 1'b0;
    held_off  = 1'b0;
    stalls_on = 1'b1;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 63) == 0) stalls_on = !stalls_on;
      if (!held_off && items_sent >= HOLD_AFTER) begin
        held_off = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rsp_ch.ready <= 1'b1;
      end else if (stalls_on && !quiet_tail && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire
